@@ design/trif_pkg.sv @@
// Shared types and codes for the triangle edge-function rasterizer.
package trif_pkg;

  localparam int EDGE_W  = 28;
  localparam int STEP_W  = 14;
  localparam int PIX_W   = 12;
  localparam int VERT_W  = 13;
  localparam int CFG_W   = 12;
  localparam int CIDX_W  = 2;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_ACCEPT = 2'd1,
    ST_CULL   = 2'd2,
    ST_VISIT  = 2'd3
  } status_t;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_STEP = 1'b1;

  localparam logic [1:0] CULL_FRONT = 2'd0;
  localparam logic [1:0] CULL_BACK  = 2'd1;

  localparam logic [CIDX_W-1:0] CFG_VP_MIN_X = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_VP_MIN_Y = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_VP_MAX_X = 2'd2;
  localparam logic [CIDX_W-1:0] CFG_VP_MAX_Y = 2'd3;

  typedef struct packed {
    logic                     kind;
    logic signed [VERT_W-1:0] v1x;
    logic signed [VERT_W-1:0] v1y;
    logic signed [VERT_W-1:0] v2x;
    logic signed [VERT_W-1:0] v2y;
    logic signed [VERT_W-1:0] v3x;
    logic signed [VERT_W-1:0] v3y;
    logic [1:0]               cull_mode;
    logic                     is_2d;
  } item_t;

  typedef struct packed {
    logic [CFG_W-1:0] min_x;
    logic [CFG_W-1:0] min_y;
    logic [CFG_W-1:0] max_x;
    logic [CFG_W-1:0] max_y;
  } viewport_t;

  typedef struct packed {
    logic                         ok;
    logic [PIX_W-1:0]             xmin;
    logic [PIX_W-1:0]             ymin;
    logic [PIX_W-1:0]             xmax;
    logic [PIX_W-1:0]             ymax;
    logic [2:0][STEP_W-1:0]       col_step;
    logic [2:0][STEP_W-1:0]       row_step;
    logic [2:0][EDGE_W-1:0]       start_edge;
  } setup_t;

  typedef struct packed {
    logic                   active;
    logic [PIX_W-1:0]       x;
    logic [PIX_W-1:0]       y;
    logic                   covered;
    logic [2:0][EDGE_W-1:0] edge_val;
    logic                   last;
  } visit_t;

endpackage

@@ design/triangle_edge_function_rasterizer_top.sv @@
// Top level of the triangle edge-function rasterizer: ports, registers and result stage.
// Every accepted word gives one result word, through the input register, then setup or
// traversal logic into the result register.
// Throughput: one word per cycle; busy stays low, so start may be held high every cycle.
// The result strobe lasts one cycle and the receiver cannot stall it.
// Reset (rst_n low, synchronous): no traversal active, viewport 0..4095 on both axes.
module triangle_edge_function_rasterizer_top #(
  parameter int COORD_BITS = 12
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_kind,
  input  logic signed [12:0] in_vertex1_x,
  input  logic signed [12:0] in_vertex1_y,
  input  logic signed [12:0] in_vertex2_x,
  input  logic signed [12:0] in_vertex2_y,
  input  logic signed [12:0] in_vertex3_x,
  input  logic signed [12:0] in_vertex3_y,
  input  logic [1:0]         in_cull_mode,
  input  logic               in_is_2d,
  output logic               out_valid,
  output logic [1:0]         out_status,
  output logic [11:0]        out_pixel_x,
  output logic [11:0]        out_pixel_y,
  output logic               out_covered,
  output logic signed [27:0] out_edge_one,
  output logic signed [27:0] out_edge_two,
  output logic signed [27:0] out_edge_three,
  output logic               out_last,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [11:0]        cfg_data
);

  trif_pkg::viewport_t vp_r, vp_nxt;
  logic                in_valid_r;
  trif_pkg::item_t     item_r;
  trif_pkg::setup_t    setup;
  trif_pkg::visit_t    visit;
  logic                load, advance, accept;

  logic                out_valid_r;
  trif_pkg::status_t   status_r, status_nxt;
  logic [11:0]         px_r, px_nxt;
  logic [11:0]         py_r, py_nxt;
  logic                cov_r, cov_nxt;
  logic [2:0][27:0]    ev_r, ev_nxt;
  logic                last_r, last_nxt;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  always_comb begin
    vp_nxt = vp_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        trif_pkg::CFG_VP_MIN_X: vp_nxt.min_x = cfg_data;
        trif_pkg::CFG_VP_MIN_Y: vp_nxt.min_y = cfg_data;
        trif_pkg::CFG_VP_MAX_X: vp_nxt.max_x = cfg_data;
        trif_pkg::CFG_VP_MAX_Y: vp_nxt.max_y = cfg_data;
        default: vp_nxt = vp_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vp_r.min_x  <= 12'd0;
      vp_r.min_y  <= 12'd0;
      vp_r.max_x  <= 12'd4095;
      vp_r.max_y  <= 12'd4095;
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      vp_r        <= vp_nxt;
      in_valid_r  <= accept;
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r.kind      <= in_kind;
      item_r.v1x       <= in_vertex1_x;
      item_r.v1y       <= in_vertex1_y;
      item_r.v2x       <= in_vertex2_x;
      item_r.v2y       <= in_vertex2_y;
      item_r.v3x       <= in_vertex3_x;
      item_r.v3y       <= in_vertex3_y;
      item_r.cull_mode <= in_cull_mode;
      item_r.is_2d     <= in_is_2d;
    end
  end

  assign load    = in_valid_r && (item_r.kind == trif_pkg::KIND_LOAD);
  assign advance = in_valid_r && (item_r.kind == trif_pkg::KIND_STEP);

  trif_setup #(
    .COORD_BITS(COORD_BITS)
  ) u_setup (
    .item  (item_r),
    .vp    (vp_r),
    .setup (setup)
  );

  trif_traverse u_traverse (
    .clk     (clk),
    .rst_n   (rst_n),
    .load    (load),
    .advance (advance),
    .setup   (setup),
    .visit   (visit)
  );

  // Only a visited position carries payload; every other status has zero fields.
  always_comb begin
    status_nxt = trif_pkg::ST_IDLE;
    px_nxt     = '0;
    py_nxt     = '0;
    cov_nxt    = 1'b0;
    ev_nxt     = '0;
    last_nxt   = 1'b0;
    if (load) begin
      status_nxt = setup.ok ? trif_pkg::ST_ACCEPT : trif_pkg::ST_CULL;
    end else if (visit.active) begin
      status_nxt = trif_pkg::ST_VISIT;
      px_nxt     = visit.x;
      py_nxt     = visit.y;
      cov_nxt    = visit.covered;
      ev_nxt     = visit.edge_val;
      last_nxt   = visit.last;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    px_r     <= px_nxt;
    py_r     <= py_nxt;
    cov_r    <= cov_nxt;
    ev_r     <= ev_nxt;
    last_r   <= last_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_status     = status_r;
  assign out_pixel_x    = px_r;
  assign out_pixel_y    = py_r;
  assign out_covered    = cov_r;
  assign out_edge_one   = ev_r[0];
  assign out_edge_two   = ev_r[1];
  assign out_edge_three = ev_r[2];
  assign out_last       = last_r;

endmodule

@@ design/trif_setup.sv @@
// Triangle setup: area and culling, clamped bounding box and initial edge values.
module trif_setup #(
  parameter int COORD_BITS = 12
) (
  input  trif_pkg::item_t     item,
  input  trif_pkg::viewport_t vp,
  output trif_pkg::setup_t    setup
);

  localparam logic signed [15:0] LIM = 16'((1 << COORD_BITS) - 1);
  localparam int NXT1 [3] = '{1, 2, 0};
  localparam int NXT2 [3] = '{2, 0, 1};

  function automatic logic signed [15:0] sx16(input logic signed [12:0] v);
    sx16 = {{3{v[12]}}, v};
  endfunction

  function automatic logic signed [15:0] min3(input logic signed [15:0] a,
                                              input logic signed [15:0] b,
                                              input logic signed [15:0] c);
    logic signed [15:0] m;
    m = (a < b) ? a : b;
    min3 = (m < c) ? m : c;
  endfunction

  function automatic logic signed [15:0] max3(input logic signed [15:0] a,
                                              input logic signed [15:0] b,
                                              input logic signed [15:0] c);
    logic signed [15:0] m;
    m = (a > b) ? a : b;
    max3 = (m > c) ? m : c;
  endfunction

  // Lower bound is tested first; in an inverted viewport only v < lo yields lo.
  function automatic logic signed [15:0] clamp_vp(input logic signed [15:0] v,
                                                  input logic [11:0] lo,
                                                  input logic [11:0] hi);
    logic signed [15:0] lo_s;
    logic signed [15:0] hi_s;
    lo_s = $signed({4'b0000, lo});
    hi_s = $signed({4'b0000, hi});
    if (v < lo_s) clamp_vp = lo_s;
    else if (v > hi_s) clamp_vp = hi_s;
    else clamp_vp = v;
  endfunction

  logic signed [12:0] vx [3];
  logic signed [12:0] vy [3];
  logic signed [13:0] d21x, d31y, d31x, d21y;
  logic signed [27:0] prod_a, prod_b;
  logic signed [28:0] area;
  logic               area_pos, area_neg, culled, back;
  logic signed [15:0] bxmin, bymin, bxmax, bymax;
  logic signed [15:0] cxmin, cymin, cxmax, cymax;
  logic signed [15:0] fxmin, fymin, fxmax, fymax;
  logic               point_box, empty_box;
  logic signed [13:0] col_raw [3];
  logic signed [13:0] row_raw [3];
  logic signed [13:0] col_s [3];
  logic signed [13:0] row_s [3];
  logic signed [14:0] off_x [3];
  logic signed [14:0] off_y [3];
  logic signed [28:0] prod_x [3];
  logic signed [28:0] prod_y [3];

  assign vx[0] = item.v1x;
  assign vx[1] = item.v2x;
  assign vx[2] = item.v3x;
  assign vy[0] = item.v1y;
  assign vy[1] = item.v2y;
  assign vy[2] = item.v3y;

  assign d21x = {item.v2x[12], item.v2x} - {item.v1x[12], item.v1x};
  assign d31y = {item.v3y[12], item.v3y} - {item.v1y[12], item.v1y};
  assign d31x = {item.v3x[12], item.v3x} - {item.v1x[12], item.v1x};
  assign d21y = {item.v2y[12], item.v2y} - {item.v1y[12], item.v1y};
  assign prod_a = d21x * d31y;
  assign prod_b = d31x * d21y;
  assign area = {prod_a[27], prod_a} - {prod_b[27], prod_b};

  assign area_neg = area[28];
  assign area_pos = !area[28] && (area != 29'sd0);
  assign culled = ((item.cull_mode == trif_pkg::CULL_FRONT) && !area_neg) ||
                  ((item.cull_mode == trif_pkg::CULL_BACK) && !area_pos);
  assign back = (item.cull_mode == trif_pkg::CULL_BACK);

  assign bxmin = min3(sx16(item.v1x), sx16(item.v2x), sx16(item.v3x));
  assign bymin = min3(sx16(item.v1y), sx16(item.v2y), sx16(item.v3y));
  assign bxmax = max3(sx16(item.v1x), sx16(item.v2x), sx16(item.v3x));
  assign bymax = max3(sx16(item.v1y), sx16(item.v2y), sx16(item.v3y));

  assign cxmin = item.is_2d ? clamp_vp(bxmin, vp.min_x, vp.max_x) : bxmin;
  assign cymin = item.is_2d ? clamp_vp(bymin, vp.min_y, vp.max_y) : bymin;
  assign cxmax = item.is_2d ? clamp_vp(bxmax, vp.min_x, vp.max_x) : bxmax;
  assign cymax = item.is_2d ? clamp_vp(bymax, vp.min_y, vp.max_y) : bymax;
  assign point_box = item.is_2d && (cxmin == cxmax) && (cymin == cymax);

  assign fxmin = (cxmin < 16'sd0) ? 16'sd0 : cxmin;
  assign fymin = (cymin < 16'sd0) ? 16'sd0 : cymin;
  assign fxmax = (cxmax > LIM) ? LIM : cxmax;
  assign fymax = (cymax > LIM) ? LIM : cymax;
  assign empty_box = (fxmin > fxmax) || (fymin > fymax);

  // Edge i is referenced to vertex NXT1[i]; its steps come from vertices NXT1 and NXT2.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      col_raw[i] = {vy[NXT2[i]][12], vy[NXT2[i]]} - {vy[NXT1[i]][12], vy[NXT1[i]]};
      row_raw[i] = {vx[NXT1[i]][12], vx[NXT1[i]]} - {vx[NXT2[i]][12], vx[NXT2[i]]};
      col_s[i] = back ? -col_raw[i] : col_raw[i];
      row_s[i] = back ? -row_raw[i] : row_raw[i];
      off_x[i] = $signed({3'b000, fxmin[11:0]}) - {{2{vx[NXT1[i]][12]}}, vx[NXT1[i]]};
      off_y[i] = $signed({3'b000, fymin[11:0]}) - {{2{vy[NXT1[i]][12]}}, vy[NXT1[i]]};
      prod_x[i] = off_x[i] * col_s[i];
      prod_y[i] = off_y[i] * row_s[i];
    end
  end

  always_comb begin
    setup.ok   = !culled && !point_box && !empty_box;
    setup.xmin = fxmin[11:0];
    setup.ymin = fymin[11:0];
    setup.xmax = fxmax[11:0];
    setup.ymax = fymax[11:0];
    for (int i = 0; i < 3; i++) begin
      setup.col_step[i]   = col_s[i];
      setup.row_step[i]   = row_s[i];
      setup.start_edge[i] = prod_x[i][27:0] + prod_y[i][27:0];
    end
  end

endmodule

@@ design/trif_traverse.sv @@
// Row-major box traversal with incremental edge function updates.
module trif_traverse (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  logic                advance,
  input  trif_pkg::setup_t    setup,
  output trif_pkg::visit_t    visit
);

  logic                   active_r, active_nxt;
  logic [11:0]            xmin_r, xmin_nxt;
  logic [11:0]            xmax_r, xmax_nxt;
  logic [11:0]            ymax_r, ymax_nxt;
  logic [11:0]            cur_x_r, cur_x_nxt;
  logic [11:0]            cur_y_r, cur_y_nxt;
  logic [2:0][13:0]       col_r, col_nxt;
  logic [2:0][13:0]       row_r, row_nxt;
  logic [2:0][27:0]       rs_r, rs_nxt;
  logic [2:0][27:0]       run_r, run_nxt;
  logic                   last;

  assign last = (cur_x_r == xmax_r) && (cur_y_r == ymax_r);

  always_comb begin
    visit.active   = active_r;
    visit.x        = cur_x_r;
    visit.y        = cur_y_r;
    visit.covered  = !run_r[0][27] && !run_r[1][27] && !run_r[2][27];
    visit.edge_val = run_r;
    visit.last     = last;
  end

  always_comb begin
    active_nxt = active_r;
    xmin_nxt   = xmin_r;
    xmax_nxt   = xmax_r;
    ymax_nxt   = ymax_r;
    cur_x_nxt  = cur_x_r;
    cur_y_nxt  = cur_y_r;
    col_nxt    = col_r;
    row_nxt    = row_r;
    rs_nxt     = rs_r;
    run_nxt    = run_r;
    if (load) begin
      // A new triangle abandons any traversal in progress.
      active_nxt = setup.ok;
      xmin_nxt   = setup.xmin;
      xmax_nxt   = setup.xmax;
      ymax_nxt   = setup.ymax;
      cur_x_nxt  = setup.xmin;
      cur_y_nxt  = setup.ymin;
      col_nxt    = setup.col_step;
      row_nxt    = setup.row_step;
      rs_nxt     = setup.start_edge;
      run_nxt    = setup.start_edge;
    end else if (advance && active_r) begin
      if (last) begin
        active_nxt = 1'b0;
      end else if (cur_x_r < xmax_r) begin
        cur_x_nxt = cur_x_r + 12'd1;
        for (int i = 0; i < 3; i++) begin
          run_nxt[i] = run_r[i] + {{14{col_r[i][13]}}, col_r[i]};
        end
      end else begin
        cur_x_nxt = xmin_r;
        cur_y_nxt = cur_y_r + 12'd1;
        for (int i = 0; i < 3; i++) begin
          rs_nxt[i]  = rs_r[i] + {{14{row_r[i][13]}}, row_r[i]};
          run_nxt[i] = rs_nxt[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
    end else begin
      active_r <= active_nxt;
    end
  end

  always_ff @(posedge clk) begin
    xmin_r  <= xmin_nxt;
    xmax_r  <= xmax_nxt;
    ymax_r  <= ymax_nxt;
    cur_x_r <= cur_x_nxt;
    cur_y_r <= cur_y_nxt;
    col_r   <= col_nxt;
    row_r   <= row_nxt;
    rs_r    <= rs_nxt;
    run_r   <= run_nxt;
  end

endmodule

@@ design/trif_checker.sv @@
// Port-level checker for the rasterizer top level and its bind statement.
module trif_port_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_valid,
  input logic [1:0]  out_status,
  input logic [11:0] out_pixel_x,
  input logic [11:0] out_pixel_y,
  input logic        out_covered,
  input logic [27:0] out_edge_one,
  input logic [27:0] out_edge_two,
  input logic [27:0] out_edge_three,
  input logic        out_last
);

  // Every accepted word produces exactly one result.
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##2 out_valid)
    else $error("accepted word produced no result");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 2))
    else $error("result without an accepted word");

  a_zero_payload: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != trif_pkg::ST_VISIT) |->
      (out_pixel_x == 12'd0 && out_pixel_y == 12'd0 && !out_covered && !out_last &&
       out_edge_one == 28'd0 && out_edge_two == 28'd0 && out_edge_three == 28'd0))
    else $error("non-visit result carries payload");

  a_covered: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == trif_pkg::ST_VISIT) |->
      (out_covered == (!out_edge_one[27] && !out_edge_two[27] && !out_edge_three[27])))
    else $error("covered flag disagrees with edge signs");

  // Back-to-back visits step one column, or wrap to the next row.
  a_scan_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == trif_pkg::ST_VISIT && !out_last) ##1
      (out_valid && out_status == trif_pkg::ST_VISIT) |->
      ((out_pixel_y == $past(out_pixel_y) && out_pixel_x == $past(out_pixel_x) + 12'd1) ||
       (out_pixel_y == $past(out_pixel_y) + 12'd1)))
    else $error("traversal left row-major order");

endmodule

bind triangle_edge_function_rasterizer_top trif_port_checker u_trif_checker (.*);
